[rtl/isc_pkg.sv]
// Shared constants, command codes and types for the itemset support counter.
package isc_pkg;

    localparam int CMD_W       = 3;
    localparam int CAND_IDX_W  = 6;
    localparam int ELEM_IDX_W  = 3;
    localparam int ITEM_W      = 16;
    localparam int TXN_W       = 12;
    localparam int CAND_SIZE_W = 4;
    localparam int NUM_CAND_W  = 7;
    localparam int SUPPORT_W   = 13;
    localparam int MATCH_W     = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;

    localparam logic [SUPPORT_W-1:0] SUPPORT_CAP = 13'd4096;

    localparam int DEF_MAX_CANDIDATES   = 64;
    localparam int DEF_MAX_ITEMSET      = 8;
    localparam int DEF_MAX_TRANSACTIONS = 4096;
    localparam int DEF_ITEM_BITS        = 16;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ITEM  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FLAGS = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_CAND_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_CAND  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SUP   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REDUCE    = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0] op;
        logic             last;
        logic             slot_ok;
        logic             elem_ok;
    } isc_ctl_t;

endpackage

[rtl/isc_front.sv]
// Front end: accepts transactions, classifies them and queues them for the engine.
module isc_front #(
    parameter int MAX_CANDIDATES   = isc_pkg::DEF_MAX_CANDIDATES,
    parameter int MAX_ITEMSET      = isc_pkg::DEF_MAX_ITEMSET,
    parameter int MAX_TRANSACTIONS = isc_pkg::DEF_MAX_TRANSACTIONS,
    parameter int ITEM_BITS        = isc_pkg::DEF_ITEM_BITS,
    localparam int CW  = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1,
    localparam int EW  = (MAX_ITEMSET > 1) ? $clog2(MAX_ITEMSET) : 1,
    localparam int TW  = $clog2(MAX_TRANSACTIONS)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept_en,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [isc_pkg::CMD_W-1:0]      s_cmd,
    input  logic [isc_pkg::CAND_IDX_W-1:0] s_cand_index,
    input  logic [isc_pkg::ELEM_IDX_W-1:0] s_elem_index,
    input  logic [isc_pkg::ITEM_W-1:0]     s_item_value,
    input  logic [isc_pkg::TXN_W-1:0]      s_txn_id,
    input  logic                          s_last_item,
    output logic                          q_valid,
    input  logic                          q_ready,
    output isc_pkg::isc_ctl_t             q_ctl,
    output logic [CW-1:0]                 q_ci,
    output logic [EW-1:0]                 q_ei,
    output logic [ITEM_BITS-1:0]          q_item,
    output logic [TW-1:0]                 q_tid
);

    isc_pkg::isc_ctl_t    ctl_q  [2];
    logic [CW-1:0]        ci_q   [2];
    logic [EW-1:0]        ei_q   [2];
    logic [ITEM_BITS-1:0] item_q [2];
    logic [TW-1:0]        tid_q  [2];

    logic [1:0] count_reg, count_next;
    logic       wp_reg, rp_reg;
    logic       push, pop;
    logic [31:0] ci32, ei32, tid32;
    logic [47:0] item48;
    isc_pkg::isc_ctl_t in_ctl;

    // The transaction number wraps by masking; MAX_TRANSACTIONS is a power of two.
    assign ci32   = 32'(s_cand_index);
    assign ei32   = 32'(s_elem_index);
    assign tid32  = 32'(s_txn_id);
    assign item48 = 48'(s_item_value);

    always_comb begin
        in_ctl.op      = s_cmd;
        in_ctl.last    = s_last_item;
        in_ctl.slot_ok = ci32 < 32'(MAX_CANDIDATES);
        in_ctl.elem_ok = ei32 < 32'(MAX_ITEMSET);
    end

    assign s_ready = accept_en && (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
            wp_reg    <= 1'b0;
            rp_reg    <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wp_reg <= !wp_reg;
            end
            if (pop) begin
                rp_reg <= !rp_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ctl_q[wp_reg]  <= in_ctl;
            ci_q[wp_reg]   <= ci32[CW-1:0];
            ei_q[wp_reg]   <= ei32[EW-1:0];
            item_q[wp_reg] <= item48[ITEM_BITS-1:0];
            tid_q[wp_reg]  <= tid32[TW-1:0];
        end
    end

    assign q_ctl  = ctl_q[rp_reg];
    assign q_ci   = ci_q[rp_reg];
    assign q_ei   = ei_q[rp_reg];
    assign q_item = item_q[rp_reg];
    assign q_tid  = tid_q[rp_reg];

endmodule

[rtl/isc_engine.sv]
// Back end: candidate table, hit and support memories, reduction flags and result register.
module isc_engine #(
    parameter int MAX_CANDIDATES   = isc_pkg::DEF_MAX_CANDIDATES,
    parameter int MAX_ITEMSET      = isc_pkg::DEF_MAX_ITEMSET,
    parameter int MAX_TRANSACTIONS = isc_pkg::DEF_MAX_TRANSACTIONS,
    parameter int ITEM_BITS        = isc_pkg::DEF_ITEM_BITS,
    localparam int CW  = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1,
    localparam int NW  = $clog2(MAX_CANDIDATES + 1),
    localparam int EW  = (MAX_ITEMSET > 1) ? $clog2(MAX_ITEMSET) : 1,
    localparam int TW  = $clog2(MAX_TRANSACTIONS)
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [isc_pkg::CAND_SIZE_W-1:0] cand_size,
    input  logic [isc_pkg::NUM_CAND_W-1:0]  num_candidates,
    input  logic [isc_pkg::SUPPORT_W-1:0]   min_support,
    input  logic                            reduction_enable,
    output logic                            init_busy,
    input  logic                            q_valid,
    output logic                            q_ready,
    input  isc_pkg::isc_ctl_t               q_ctl,
    input  logic [CW-1:0]                   q_ci,
    input  logic [EW-1:0]                   q_ei,
    input  logic [ITEM_BITS-1:0]            q_item,
    input  logic [TW-1:0]                   q_tid,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [isc_pkg::SUPPORT_W-1:0]   m_support,
    output logic                            m_is_frequent,
    output logic [isc_pkg::MATCH_W-1:0]     m_matched_candidates,
    output logic                            m_txn_useful,
    output logic                            m_txn_skipped
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FLAG  = 3'd1;
    localparam logic [2:0] ST_LOOP  = 3'd2;
    localparam logic [2:0] ST_LAST  = 3'd3;
    localparam logic [2:0] ST_END   = 3'd4;
    localparam logic [2:0] ST_QUERY = 3'd5;
    localparam logic [2:0] ST_SWEEP = 3'd6;
    localparam logic [2:0] ST_RESP  = 3'd7;

    logic [2:0]   state_reg;
    logic         init_reg;
    logic [CW-1:0] cidx_reg;
    logic [TW-1:0] sweep_reg;
    logic         p_vld_reg;
    logic [CW-1:0] p_idx_reg;
    logic [NW-1:0] matched_reg;

    logic [isc_pkg::SUPPORT_W-1:0] res_sup_reg;
    logic                          res_freq_reg;
    logic [isc_pkg::MATCH_W-1:0]   res_match_reg;
    logic                          res_useful_reg;
    logic                          res_skip_reg;

    logic [ITEM_BITS-1:0] cand_rd [MAX_ITEMSET];
    logic [MAX_ITEMSET-1:0] hit_mem [MAX_CANDIDATES];
    logic [MAX_ITEMSET-1:0] hit_rd;
    logic [MAX_CANDIDATES-1:0] hit_vld_reg;
    logic                   hit_vld_rd;
    logic [isc_pkg::SUPPORT_W-1:0] sup_mem [MAX_CANDIDATES];
    logic [isc_pkg::SUPPORT_W-1:0] sup_rd;
    logic [MAX_CANDIDATES-1:0] sup_vld_reg;
    logic                   sup_vld_rd;
    logic                   useless_mem [MAX_TRANSACTIONS];
    logic                   useless_rd;

    logic [CW-1:0]          rd_addr;
    logic [31:0]            count32;
    logic [NW-1:0]          count_eff;
    logic                   last_row;
    logic [MAX_ITEMSET-1:0] full_mask;
    logic [MAX_ITEMSET-1:0] eq_vec;
    logic [MAX_ITEMSET-1:0] hits_new;
    logic                   row_full;
    logic [isc_pkg::SUPPORT_W-1:0] sup_cur;
    logic [isc_pkg::SUPPORT_W-1:0] sup_new;
    logic                   use_we;
    logic [TW-1:0]          use_wa;
    logic                   load_we;
    logic [31:0]            match32;
    logic                   resp_go;

    assign init_busy = init_reg;
    assign rd_addr   = (state_reg == ST_IDLE) ? q_ci : cidx_reg;
    assign count32   = (32'(num_candidates) > 32'(MAX_CANDIDATES)) ?
                       32'(MAX_CANDIDATES) : 32'(num_candidates);
    assign count_eff = count32[NW-1:0];
    assign last_row  = (32'(cidx_reg) + 32'd1) == count32;
    assign load_we   = (state_reg == ST_IDLE) && q_valid && (q_ctl.op == isc_pkg::CMD_LOAD)
                       && q_ctl.slot_ok && q_ctl.elem_ok;

    genvar ge;
    generate
        for (ge = 0; ge < MAX_ITEMSET; ge++) begin : g_elem
            logic [ITEM_BITS-1:0] cand_mem [MAX_CANDIDATES];
            always_ff @(posedge aclk) begin
                if (load_we && (32'(q_ei) == ge)) begin
                    cand_mem[q_ci] <= q_item;
                end
                cand_rd[ge] <= cand_mem[rd_addr];
            end
            assign full_mask[ge] = 32'(ge) < 32'(cand_size);
            assign eq_vec[ge]    = full_mask[ge] && (cand_rd[ge] == q_item);
        end
    endgenerate

    assign hits_new = (hit_vld_rd ? hit_rd : '0) | eq_vec;
    assign row_full = (hits_new & full_mask) == full_mask;
    assign sup_cur  = sup_vld_rd ? sup_rd : '0;
    assign sup_new  = (sup_cur < isc_pkg::SUPPORT_CAP) ? sup_cur + 1'b1 : sup_cur;
    assign match32  = 32'(matched_reg);

    always_comb begin
        use_we = 1'b0;
        use_wa = q_tid;
        if (state_reg == ST_SWEEP) begin
            use_we = 1'b1;
            use_wa = sweep_reg;
        end else if (state_reg == ST_END && reduction_enable && matched_reg == '0) begin
            use_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (use_we) begin
            useless_mem[use_wa] <= (state_reg != ST_SWEEP);
        end
        useless_rd <= useless_mem[q_tid];
        hit_rd     <= hit_mem[rd_addr];
        hit_vld_rd <= hit_vld_reg[rd_addr];
        sup_rd     <= sup_mem[rd_addr];
        sup_vld_rd <= sup_vld_reg[rd_addr];
        if (p_vld_reg) begin
            hit_mem[p_idx_reg] <= hits_new;
            if (q_ctl.last && row_full) begin
                sup_mem[p_idx_reg] <= sup_new;
            end
        end
    end

    assign resp_go = !m_valid || m_ready;
    assign q_ready = (state_reg == ST_RESP) && resp_go;

    always_ff @(posedge aclk) begin
        p_idx_reg <= cidx_reg;
        if (!aresetn) begin
            state_reg     <= ST_SWEEP;
            init_reg      <= 1'b1;
            sweep_reg     <= '0;
            cidx_reg      <= '0;
            p_vld_reg     <= 1'b0;
            matched_reg   <= '0;
            hit_vld_reg   <= '0;
            sup_vld_reg   <= '0;
            m_valid       <= 1'b0;
        end else begin
            p_vld_reg <= (state_reg == ST_LOOP);
            if (m_valid && m_ready && (state_reg != ST_RESP)) begin
                m_valid <= 1'b0;
            end
            if (p_vld_reg) begin
                hit_vld_reg[p_idx_reg] <= 1'b1;
                if (q_ctl.last && row_full) begin
                    sup_vld_reg[p_idx_reg] <= 1'b1;
                    matched_reg            <= matched_reg + 1'b1;
                end
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        res_sup_reg    <= '0;
                        res_freq_reg   <= 1'b0;
                        res_match_reg  <= '0;
                        res_useful_reg <= 1'b0;
                        res_skip_reg   <= 1'b0;
                        unique case (q_ctl.op)
                            isc_pkg::CMD_ITEM:  state_reg <= ST_FLAG;
                            isc_pkg::CMD_CLEAR: begin
                                sup_vld_reg <= '0;
                                state_reg   <= ST_RESP;
                            end
                            isc_pkg::CMD_FLAGS: begin
                                sweep_reg <= '0;
                                state_reg <= ST_SWEEP;
                            end
                            isc_pkg::CMD_QUERY: state_reg <= ST_QUERY;
                            default:            state_reg <= ST_RESP;
                        endcase
                    end
                end
                ST_FLAG: begin
                    matched_reg <= '0;
                    cidx_reg    <= '0;
                    if (reduction_enable && useless_rd) begin
                        res_skip_reg <= 1'b1;
                        if (q_ctl.last) begin
                            hit_vld_reg <= '0;
                        end
                        state_reg <= ST_RESP;
                    end else if (count_eff == '0) begin
                        state_reg <= q_ctl.last ? ST_END : ST_RESP;
                    end else begin
                        state_reg <= ST_LOOP;
                    end
                end
                ST_LOOP: begin
                    if (last_row) begin
                        state_reg <= ST_LAST;
                    end else begin
                        cidx_reg <= cidx_reg + 1'b1;
                    end
                end
                ST_LAST: begin
                    state_reg <= q_ctl.last ? ST_END : ST_RESP;
                end
                ST_END: begin
                    hit_vld_reg    <= '0;
                    res_match_reg  <= match32[isc_pkg::MATCH_W-1:0];
                    res_useful_reg <= !useless_rd && !(reduction_enable && matched_reg == '0);
                    state_reg      <= ST_RESP;
                end
                ST_QUERY: begin
                    if (q_ctl.slot_ok) begin
                        res_sup_reg  <= sup_cur;
                        res_freq_reg <= sup_cur >= min_support;
                    end
                    state_reg <= ST_RESP;
                end
                ST_SWEEP: begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == TW'(MAX_TRANSACTIONS - 1)) begin
                        init_reg  <= 1'b0;
                        state_reg <= init_reg ? ST_IDLE : ST_RESP;
                    end
                end
                ST_RESP: begin
                    if (resp_go) begin
                        m_valid   <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_RESP && resp_go) begin
            m_support            <= res_sup_reg;
            m_is_frequent        <= res_freq_reg;
            m_matched_candidates <= res_match_reg;
            m_txn_useful         <= res_useful_reg;
            m_txn_skipped        <= res_skip_reg;
        end
    end

endmodule

[rtl/itemset_support_counter_unit.sv]
// Steps: a transaction item checks its flag, then scans the candidate rows, one candidate row a cycle,
// and a last item closes the transaction before the answer. Loads, clears and unused commands
// answer directly, queries read the support first, and a flag reset sweeps all transaction flags.
// Throughput: one transaction at a time in the engine, set by the candidate row scan.
// Reset: synchronous active-low aresetn; afterwards a pass over all MAX_TRANSACTIONS flags marks every
// transaction useful while s_ready stays low. Configuration writes are taken at any time.
module itemset_support_counter_unit #(
    parameter int MAX_CANDIDATES   = isc_pkg::DEF_MAX_CANDIDATES,
    parameter int MAX_ITEMSET      = isc_pkg::DEF_MAX_ITEMSET,
    parameter int MAX_TRANSACTIONS = isc_pkg::DEF_MAX_TRANSACTIONS,
    parameter int ITEM_BITS        = isc_pkg::DEF_ITEM_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [isc_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [isc_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [isc_pkg::CMD_W-1:0]      s_cmd,
    input  logic [isc_pkg::CAND_IDX_W-1:0] s_cand_index,
    input  logic [isc_pkg::ELEM_IDX_W-1:0] s_elem_index,
    input  logic [isc_pkg::ITEM_W-1:0]     s_item_value,
    input  logic [isc_pkg::TXN_W-1:0]      s_txn_id,
    input  logic                           s_last_item,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [isc_pkg::SUPPORT_W-1:0]  m_support,
    output logic                           m_is_frequent,
    output logic [isc_pkg::MATCH_W-1:0]    m_matched_candidates,
    output logic                           m_txn_useful,
    output logic                           m_txn_skipped
);

    localparam int CW = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
    localparam int EW = (MAX_ITEMSET > 1) ? $clog2(MAX_ITEMSET) : 1;
    localparam int TW = $clog2(MAX_TRANSACTIONS);

    logic [isc_pkg::CAND_SIZE_W-1:0] cand_size_reg;
    logic [isc_pkg::NUM_CAND_W-1:0]  num_cand_reg;
    logic [isc_pkg::SUPPORT_W-1:0]   min_sup_reg;
    logic                            reduce_reg;

    logic                 init_busy;
    logic                 q_valid, q_ready;
    isc_pkg::isc_ctl_t    q_ctl;
    logic [CW-1:0]        q_ci;
    logic [EW-1:0]        q_ei;
    logic [ITEM_BITS-1:0] q_item;
    logic [TW-1:0]        q_tid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cand_size_reg <= 4'd2;
            num_cand_reg  <= '0;
            min_sup_reg   <= 13'd1;
            reduce_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                isc_pkg::REG_CAND_SIZE: cand_size_reg <= cfg_wr_data[isc_pkg::CAND_SIZE_W-1:0];
                isc_pkg::REG_NUM_CAND:  num_cand_reg  <= cfg_wr_data[isc_pkg::NUM_CAND_W-1:0];
                isc_pkg::REG_MIN_SUP:   min_sup_reg   <= cfg_wr_data;
                isc_pkg::REG_REDUCE:    reduce_reg    <= cfg_wr_data[0];
                default:                reduce_reg    <= reduce_reg;
            endcase
        end
    end

    isc_front #(
        .MAX_CANDIDATES  (MAX_CANDIDATES),
        .MAX_ITEMSET     (MAX_ITEMSET),
        .MAX_TRANSACTIONS(MAX_TRANSACTIONS),
        .ITEM_BITS       (ITEM_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept_en   (!init_busy),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_cand_index(s_cand_index),
        .s_elem_index(s_elem_index),
        .s_item_value(s_item_value),
        .s_txn_id    (s_txn_id),
        .s_last_item (s_last_item),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_ctl       (q_ctl),
        .q_ci        (q_ci),
        .q_ei        (q_ei),
        .q_item      (q_item),
        .q_tid       (q_tid)
    );

    isc_engine #(
        .MAX_CANDIDATES  (MAX_CANDIDATES),
        .MAX_ITEMSET     (MAX_ITEMSET),
        .MAX_TRANSACTIONS(MAX_TRANSACTIONS),
        .ITEM_BITS       (ITEM_BITS)
    ) u_engine (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cand_size           (cand_size_reg),
        .num_candidates      (num_cand_reg),
        .min_support         (min_sup_reg),
        .reduction_enable    (reduce_reg),
        .init_busy           (init_busy),
        .q_valid             (q_valid),
        .q_ready             (q_ready),
        .q_ctl               (q_ctl),
        .q_ci                (q_ci),
        .q_ei                (q_ei),
        .q_item              (q_item),
        .q_tid               (q_tid),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_support           (m_support),
        .m_is_frequent       (m_is_frequent),
        .m_matched_candidates(m_matched_candidates),
        .m_txn_useful        (m_txn_useful),
        .m_txn_skipped       (m_txn_skipped)
    );

endmodule
